### rtl/radial_cosine_image_blend_assert.svh
// Assertion macros for the radial cosine blend.
// Clocked on clk with disable on rst; used by the top level.
`ifndef RADIAL_COSINE_IMAGE_BLEND_ASSERT_SVH
`define RADIAL_COSINE_IMAGE_BLEND_ASSERT_SVH

// Property that must hold at every edge out of reset
`define RCIB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies the consequent in the next
`define RCIB_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### rtl/rcib_pkg.sv
// Shared types, constants and the cosine weight function for the blend.
// No dependencies.
package rcib_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int DIFF_W     = 13;
  localparam int SQ_W       = 25;
  localparam int QUO_W      = 20;
  localparam int ROOT_W     = 10;
  localparam int SREM_W     = 13;
  localparam int PHASE_W    = 11;
  localparam int TAB_N      = 1025;
  localparam int DIV_CELLS  = 20;
  localparam int SQRT_CELLS = 10;
  localparam int WFN_W      = 25;

  localparam logic [PHASE_W-1:0] PHASE_FULL = 11'd1024;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] a_b;
    logic [PIX_W-1:0] a_g;
    logic [PIX_W-1:0] a_r;
    logic [PIX_W-1:0] b_b;
    logic [PIX_W-1:0] b_g;
    logic [PIX_W-1:0] b_r;
  } pix_t;

  // special-case flags that ride along the chain
  typedef struct packed {
    logic r2zero;
    logic d2zero;
    logic beyond;
  } flag_t;

  // Raised-cosine weight for phase u (1024 = pi), evaluated at elaboration
  function automatic logic [WFN_W-1:0] cos_weight(input int unsigned u, input int unsigned wb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] w;
    x    = (64'd3373259426 * 64'(u)) >> 11;
    x2   = (x * x) >> 30;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    term = 64'd1 << 30;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    c = (pos > neg) ? pos - neg : 64'd0;
    if (c > (64'd1 << 30)) c = 64'd1 << 30;
    w = (c * c + (64'd1 << (59 - wb))) >> (60 - wb);
    return w[WFN_W-1:0];
  endfunction

endpackage

### rtl/rcib_div_cell.sv
// One restoring-division cell: yields one quotient bit of d2*2^20/r2 a cycle.
// Depends on rcib_pkg.
module rcib_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [rcib_pkg::SQ_W-1:0]   in_rem,
  input  logic [rcib_pkg::QUO_W-1:0]  in_quo,
  input  rcib_pkg::flag_t             in_flag,
  input  rcib_pkg::pix_t              in_pix,
  input  logic [rcib_pkg::SQ_W-1:0]   r2,
  output logic                        out_valid,
  output logic [rcib_pkg::SQ_W-1:0]   out_rem,
  output logic [rcib_pkg::QUO_W-1:0]  out_quo,
  output rcib_pkg::flag_t             out_flag,
  output rcib_pkg::pix_t              out_pix
);

  logic [rcib_pkg::SQ_W:0]   shifted;
  logic                      take;
  logic [rcib_pkg::SQ_W:0]   diff;

  // shift remainder, trial subtract
  always_comb begin
    shifted = {in_rem, 1'b0};
    take    = shifted >= {1'b0, r2};
    diff    = shifted - {1'b0, r2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= take ? diff[rcib_pkg::SQ_W-1:0] : shifted[rcib_pkg::SQ_W-1:0];
    out_quo  <= {in_quo[rcib_pkg::QUO_W-2:0], take};
    out_flag <= in_flag;
    out_pix  <= in_pix;
  end

endmodule

### rtl/rcib_sqrt_cell.sv
// One digit-by-digit square root cell: one root bit a cycle.
// Depends on rcib_pkg.
module rcib_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rcib_pkg::QUO_W-1:0]   in_rad,
  input  logic [rcib_pkg::SREM_W-1:0]  in_rem,
  input  logic [rcib_pkg::ROOT_W-1:0]  in_root,
  input  rcib_pkg::flag_t              in_flag,
  input  rcib_pkg::pix_t               in_pix,
  output logic                         out_valid,
  output logic [rcib_pkg::QUO_W-1:0]   out_rad,
  output logic [rcib_pkg::SREM_W-1:0]  out_rem,
  output logic [rcib_pkg::ROOT_W-1:0]  out_root,
  output rcib_pkg::flag_t              out_flag,
  output rcib_pkg::pix_t               out_pix
);

  logic [rcib_pkg::SREM_W-1:0] cur;
  logic [rcib_pkg::SREM_W-1:0] trial;
  logic                        take;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    cur   = {in_rem[rcib_pkg::SREM_W-3:0], in_rad[rcib_pkg::QUO_W-1 -: 2]};
    trial = {1'b0, in_root, 2'b01};
    take  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= {in_rad[rcib_pkg::QUO_W-3:0], 2'b00};
    out_rem  <= take ? cur - trial : cur;
    out_root <= {in_root[rcib_pkg::ROOT_W-2:0], take};
    out_flag <= in_flag;
    out_pix  <= in_pix;
  end

endmodule

### rtl/radial_cosine_image_blend.sv
// Radial cosine blend. One pixel per clock, busy is always low. Cost is
// set by the 20-cell divider chain and the 10-cell square root chain, one
// bit per cell. Results cannot be stalled.
// Synchronous active-high rst clears pipeline valids and sets both sizes to 512.
// Depends on rcib_pkg, rcib_div_cell, rcib_sqrt_cell and the assertion header.
`include "radial_cosine_image_blend_assert.svh"
module radial_cosine_image_blend #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          write_en,
  input  logic                          reg_index,
  input  logic [rcib_pkg::DIM_W-1:0]    write_data,
  input  logic [rcib_pkg::POS_W-1:0]    pixel_row,
  input  logic [rcib_pkg::POS_W-1:0]    pixel_col,
  input  logic [rcib_pkg::PIX_W-1:0]    first_blue,
  input  logic [rcib_pkg::PIX_W-1:0]    first_green,
  input  logic [rcib_pkg::PIX_W-1:0]    first_red,
  input  logic [rcib_pkg::PIX_W-1:0]    second_blue,
  input  logic [rcib_pkg::PIX_W-1:0]    second_green,
  input  logic [rcib_pkg::PIX_W-1:0]    second_red,
  output logic                          done,
  output logic [rcib_pkg::PIX_W-1:0]    blend_blue,
  output logic [rcib_pkg::PIX_W-1:0]    blend_green,
  output logic [rcib_pkg::PIX_W-1:0]    blend_red
);

  localparam int LAT   = 3 + rcib_pkg::DIV_CELLS + rcib_pkg::SQRT_CELLS + 2;
  localparam int MIX_W = WEIGHT_BITS + 1 + rcib_pkg::PIX_W + 1;
  localparam int DN    = rcib_pkg::DIV_CELLS;
  localparam int SN    = rcib_pkg::SQRT_CELLS;

  logic [rcib_pkg::DIM_W-1:0] rows;
  logic [rcib_pkg::DIM_W-1:0] cols;
  logic [rcib_pkg::SQ_W-1:0]  cx2;
  logic [rcib_pkg::SQ_W-1:0]  cy2;
  logic [rcib_pkg::SQ_W-1:0]  r2;
  logic                       accepted;

  assign busy     = 1'b0;
  assign accepted = start && !busy;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= 13'd512;
      cols <= 13'd512;
    end else if (write_en) begin
      case (reg_index)
        rcib_pkg::REG_ROWS: rows <= write_data;
        rcib_pkg::REG_COLS: cols <= write_data;
        default: ;
      endcase
    end
  end

  // squared radius, two registered steps after a size write
  always_ff @(posedge clk) begin
    cx2 <= rcib_pkg::SQ_W'(cols[rcib_pkg::DIM_W-1:1]) *
           rcib_pkg::SQ_W'(cols[rcib_pkg::DIM_W-1:1]);
    cy2 <= rcib_pkg::SQ_W'(rows[rcib_pkg::DIM_W-1:1]) *
           rcib_pkg::SQ_W'(rows[rcib_pkg::DIM_W-1:1]);
    r2  <= cx2 + cy2;
  end

  // stage 1: offsets from center
  logic                               v1;
  logic signed [rcib_pkg::DIFF_W-1:0] dx1;
  logic signed [rcib_pkg::DIFF_W-1:0] dy1;
  rcib_pkg::pix_t                     p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accepted;
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= $signed({1'b0, pixel_col}) - $signed({1'b0, cols[rcib_pkg::DIM_W-1:1]});
    dy1 <= $signed({1'b0, pixel_row}) - $signed({1'b0, rows[rcib_pkg::DIM_W-1:1]});
    p1  <= '{first_blue, first_green, first_red, second_blue, second_green, second_red};
  end

  // stage 2: squares, operands sign-extended to the full square width
  logic                      v2;
  logic [rcib_pkg::SQ_W-1:0] dx2;
  logic [rcib_pkg::SQ_W-1:0] dy2;
  rcib_pkg::pix_t            p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx2 <= $unsigned(rcib_pkg::SQ_W'(dx1) * rcib_pkg::SQ_W'(dx1));
    dy2 <= $unsigned(rcib_pkg::SQ_W'(dy1) * rcib_pkg::SQ_W'(dy1));
    p2  <= p1;
  end

  // stage 3: distance squared and special cases
  logic                      v3;
  logic [rcib_pkg::SQ_W-1:0] d2;
  logic [rcib_pkg::SQ_W:0]   d2_sum;
  rcib_pkg::flag_t           f3;
  rcib_pkg::pix_t            p3;

  assign d2_sum = {1'b0, dx2} + {1'b0, dy2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d2        <= d2_sum[rcib_pkg::SQ_W-1:0];
    f3.r2zero <= r2 == '0;
    f3.d2zero <= d2_sum == '0;
    f3.beyond <= d2_sum >= {1'b0, r2};
    p3        <= p2;
  end

  // divider chain
  logic                       dv [0:DN];
  logic [rcib_pkg::SQ_W-1:0]  drem [0:DN];
  logic [rcib_pkg::QUO_W-1:0] dquo [0:DN];
  rcib_pkg::flag_t            dflag [0:DN];
  rcib_pkg::pix_t             dpix [0:DN];

  assign dv[0]    = v3;
  assign drem[0]  = d2;
  assign dquo[0]  = '0;
  assign dflag[0] = f3;
  assign dpix[0]  = p3;

  for (genvar i = 0; i < DN; i++) begin : g_div
    rcib_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[i]),
      .in_rem    (drem[i]),
      .in_quo    (dquo[i]),
      .in_flag   (dflag[i]),
      .in_pix    (dpix[i]),
      .r2        (r2),
      .out_valid (dv[i+1]),
      .out_rem   (drem[i+1]),
      .out_quo   (dquo[i+1]),
      .out_flag  (dflag[i+1]),
      .out_pix   (dpix[i+1])
    );
  end

  // square root chain
  logic                        sv [0:SN];
  logic [rcib_pkg::QUO_W-1:0]  srad [0:SN];
  logic [rcib_pkg::SREM_W-1:0] srem [0:SN];
  logic [rcib_pkg::ROOT_W-1:0] sroot [0:SN];
  rcib_pkg::flag_t             sflag [0:SN];
  rcib_pkg::pix_t              spix [0:SN];

  assign sv[0]    = dv[DN];
  assign srad[0]  = dquo[DN];
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sflag[0] = dflag[DN];
  assign spix[0]  = dpix[DN];

  for (genvar i = 0; i < SN; i++) begin : g_sqrt
    rcib_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[i]),
      .in_rad    (srad[i]),
      .in_rem    (srem[i]),
      .in_root   (sroot[i]),
      .in_flag   (sflag[i]),
      .in_pix    (spix[i]),
      .out_valid (sv[i+1]),
      .out_rad   (srad[i+1]),
      .out_rem   (srem[i+1]),
      .out_root  (sroot[i+1]),
      .out_flag  (sflag[i+1]),
      .out_pix   (spix[i+1])
    );
  end

  // weight table, built at elaboration
  logic [WEIGHT_BITS:0] wtab [0:rcib_pkg::TAB_N-1];

  for (genvar g = 0; g < rcib_pkg::TAB_N; g++) begin : g_tab
    localparam logic [rcib_pkg::WFN_W-1:0] WV = rcib_pkg::cos_weight(g, WEIGHT_BITS);
    assign wtab[g] = WV[WEIGHT_BITS:0];
  end

  // phase selection and table lookup
  rcib_pkg::flag_t              sf;
  logic [rcib_pkg::PHASE_W-1:0] phase;
  logic                         tv;
  logic [WEIGHT_BITS:0]         tw;
  rcib_pkg::pix_t               tpix;

  assign sf = sflag[SN];

  always_comb begin
    if (sf.r2zero) begin
      phase = sf.d2zero ? '0 : rcib_pkg::PHASE_FULL;
    end else if (sf.beyond) begin
      phase = rcib_pkg::PHASE_FULL;
    end else begin
      phase = {1'b0, sroot[SN]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= sv[SN];
    end
  end

  always_ff @(posedge clk) begin
    tw   <= wtab[phase];
    tpix <= spix[SN];
  end

  // per-channel mix, round and saturate
  logic [WEIGHT_BITS:0] tw_inv;
  logic [MIX_W-1:0]     mb;
  logic [MIX_W-1:0]     mg;
  logic [MIX_W-1:0]     mr;
  logic [MIX_W-1:0]     half;

  always_comb begin
    tw_inv = {1'b1, {WEIGHT_BITS{1'b0}}} - tw;
    half   = MIX_W'(1) << (WEIGHT_BITS - 1);
    mb = (MIX_W'(tpix.a_b) * MIX_W'(tw) + MIX_W'(tpix.b_b) * MIX_W'(tw_inv) + half)
         >> WEIGHT_BITS;
    mg = (MIX_W'(tpix.a_g) * MIX_W'(tw) + MIX_W'(tpix.b_g) * MIX_W'(tw_inv) + half)
         >> WEIGHT_BITS;
    mr = (MIX_W'(tpix.a_r) * MIX_W'(tw) + MIX_W'(tpix.b_r) * MIX_W'(tw_inv) + half)
         >> WEIGHT_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tv;
    end
  end

  always_ff @(posedge clk) begin
    blend_blue  <= (mb > MIX_W'(255)) ? 8'hFF : mb[rcib_pkg::PIX_W-1:0];
    blend_green <= (mg > MIX_W'(255)) ? 8'hFF : mg[rcib_pkg::PIX_W-1:0];
    blend_red   <= (mr > MIX_W'(255)) ? 8'hFF : mr[rcib_pkg::PIX_W-1:0];
  end

  // checks
  `RCIB_ASSERT(a_latency, accepted |-> ##LAT done, "transfer did not emerge after pipeline latency")
  `RCIB_ASSERT(a_done_src, done |-> $past(tv), "done without a weighted item")
  `RCIB_ASSERT_NEXT(a_zero_w, tv && tw == '0, blend_blue == $past(tpix.b_b), "zero weight must pass second image")
  `RCIB_ASSERT_NEXT(a_full_phase, sv[SN] && !sf.r2zero && sf.beyond, tw == '0, "pixel beyond radius must get zero weight")

endmodule
